/* hw/rtl/fesg_pkg.sv */
package fesg_pkg;

  localparam int MAX_SEMI_AXIS_DEF = 31;

  localparam int POS_W   = 9;
  localparam int SIZE_W  = 6;
  localparam int COLOR_W = 16;
  localparam int COORD_W = 11;
  localparam int AXIS_W  = 5;
  localparam int X_W     = 6;
  localparam int DX_W    = 7;
  localparam int XS_W    = 8;
  localparam int SQ_W    = 10;
  localparam int OPA_W   = 10;
  localparam int OPB_W   = 12;
  localparam int PROD_W  = 22;
  localparam int AB_W    = 20;
  localparam int STEP_W  = 4;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_XINIT,
    ACT_CMP,
    ACT_ADVANCE
  } act_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_A2B2,
    MUL_YY,
    MUL_A2YY,
    MUL_XX,
    MUL_B2XX
  } mul_t;

  typedef enum logic [1:0] {
    SPAN_NONE,
    SPAN_CENTRE,
    SPAN_BELOW,
    SPAN_ABOVE
  } span_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_B_ZERO,
    JMP_X_ZERO,
    JMP_OUTSIDE,
    JMP_LAST_ROW
  } jmp_t;

  typedef struct packed {
    act_t              act;
    mul_t              mul;
    span_t             span;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic  go;
    act_t  act;
    mul_t  mul;
    span_t span;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic b_zero;
    logic x_zero;
    logic outside;
    logic last_row;
  } stat_t;

endpackage

/* hw/rtl/fesg_useq.sv */
module fesg_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fesg_pkg::stat_t stat,
  output fesg_pkg::ctrl_t ctrl
);

  localparam logic [fesg_pkg::STEP_W-1:0] STEP_FETCH  = 4'd0;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_AA     = 4'd1;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_BB     = 4'd2;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_A2B2   = 4'd3;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_CENTRE = 4'd4;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_ROW    = 4'd5;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_A2YY   = 4'd6;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_TEST   = 4'd7;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_XX     = 4'd8;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_B2XX   = 4'd9;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_CMP    = 4'd10;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_BELOW  = 4'd11;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_ABOVE  = 4'd12;
  localparam logic [fesg_pkg::STEP_W-1:0] STEP_ADV    = 4'd13;

  function automatic fesg_pkg::uword_t ucode(input logic [fesg_pkg::STEP_W-1:0] s);
    fesg_pkg::uword_t w;
    w = '{fesg_pkg::ACT_NONE, fesg_pkg::MUL_NONE, fesg_pkg::SPAN_NONE,
          fesg_pkg::JMP_ALWAYS, STEP_FETCH};
    unique case (s)
      STEP_FETCH: begin
        w.act = fesg_pkg::ACT_LOAD;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_AA: begin
        w.mul = fesg_pkg::MUL_AA;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_BB: begin
        w.mul = fesg_pkg::MUL_BB;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_A2B2: begin
        w.mul = fesg_pkg::MUL_A2B2;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_CENTRE: begin
        w.span   = fesg_pkg::SPAN_CENTRE;
        w.jmp    = fesg_pkg::JMP_B_ZERO;
        w.target = STEP_FETCH;
      end
      STEP_ROW: begin
        w.act = fesg_pkg::ACT_XINIT;
        w.mul = fesg_pkg::MUL_YY;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_A2YY: begin
        w.mul = fesg_pkg::MUL_A2YY;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_TEST: begin
        w.jmp    = fesg_pkg::JMP_X_ZERO;
        w.target = STEP_BELOW;
      end
      STEP_XX: begin
        w.mul = fesg_pkg::MUL_XX;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_B2XX: begin
        w.mul = fesg_pkg::MUL_B2XX;
        w.jmp = fesg_pkg::JMP_NEXT;
      end
      STEP_CMP: begin
        w.act    = fesg_pkg::ACT_CMP;
        w.jmp    = fesg_pkg::JMP_OUTSIDE;
        w.target = STEP_TEST;
      end
      STEP_BELOW: begin
        w.span = fesg_pkg::SPAN_BELOW;
        w.jmp  = fesg_pkg::JMP_NEXT;
      end
      STEP_ABOVE: begin
        w.span   = fesg_pkg::SPAN_ABOVE;
        w.jmp    = fesg_pkg::JMP_LAST_ROW;
        w.target = STEP_FETCH;
      end
      STEP_ADV: begin
        w.act    = fesg_pkg::ACT_ADVANCE;
        w.target = STEP_ROW;
      end
      default: begin
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

  logic [fesg_pkg::STEP_W-1:0] step_r, step_nxt;
  fesg_pkg::uword_t            uw;
  logic                        stall;
  logic                        taken;

  assign uw = ucode(step_r);

  always_comb begin
    stall = ((uw.act == fesg_pkg::ACT_LOAD) && !(in_valid && rst_n)) ||
            ((uw.span != fesg_pkg::SPAN_NONE) && !stat.out_free);
  end

  always_comb begin
    unique case (uw.jmp)
      fesg_pkg::JMP_NEXT:     taken = 1'b0;
      fesg_pkg::JMP_ALWAYS:   taken = 1'b1;
      fesg_pkg::JMP_B_ZERO:   taken = stat.b_zero;
      fesg_pkg::JMP_X_ZERO:   taken = stat.x_zero;
      fesg_pkg::JMP_OUTSIDE:  taken = stat.outside;
      fesg_pkg::JMP_LAST_ROW: taken = stat.last_row;
      default:                taken = 1'b1;
    endcase
  end

  always_comb begin
    priority if (stall) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_ready  = rst_n && (uw.act == fesg_pkg::ACT_LOAD);
  assign ctrl.go   = !stall;
  assign ctrl.act  = uw.act;
  assign ctrl.mul  = uw.mul;
  assign ctrl.span = uw.span;

  a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_ADV)
    else $error("sequencer left the program");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> step_r == $past(step_r))
    else $error("step moved while stalled");

  a_fetch_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_ABOVE && !stall && stat.last_row) |=> step_r == STEP_FETCH)
    else $error("no return to fetch after final span");

endmodule

/* hw/rtl/fesg_datapath.sv */
module fesg_datapath #(
  parameter int MAX_SEMI_AXIS = fesg_pkg::MAX_SEMI_AXIS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fesg_pkg::ctrl_t                     ctrl,
  output fesg_pkg::stat_t                     stat,
  input  logic        [fesg_pkg::POS_W-1:0]   in_center_x,
  input  logic        [fesg_pkg::POS_W-1:0]   in_center_y,
  input  logic        [fesg_pkg::SIZE_W-1:0]  in_box_width,
  input  logic        [fesg_pkg::SIZE_W-1:0]  in_box_height,
  input  logic        [fesg_pkg::COLOR_W-1:0] in_fill_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fesg_pkg::COORD_W-1:0] out_span_left,
  output logic signed [fesg_pkg::COORD_W-1:0] out_span_right,
  output logic signed [fesg_pkg::COORD_W-1:0] out_span_row,
  output logic        [fesg_pkg::COLOR_W-1:0] out_span_color,
  output logic                                out_last_span
);

  localparam logic [fesg_pkg::AXIS_W-1:0] AXIS_MAX = fesg_pkg::AXIS_W'(MAX_SEMI_AXIS);

  logic [fesg_pkg::POS_W-1:0]   cx_r, cy_r;
  logic [fesg_pkg::COLOR_W-1:0] color_r;
  logic [fesg_pkg::AXIS_W-1:0]  a_r, b_r, y_r;
  logic [fesg_pkg::SQ_W-1:0]    a2_r, b2_r;
  logic [fesg_pkg::AB_W-1:0]    a2b2_r, ay_r;
  logic [fesg_pkg::PROD_W-1:0]  p_r;
  logic [fesg_pkg::X_W-1:0]     x_r, x0_r;
  logic signed [fesg_pkg::DX_W-1:0] dx_r;

  logic [fesg_pkg::AXIS_W-1:0]  a_in, b_in;
  logic [fesg_pkg::OPA_W-1:0]   opa;
  logic [fesg_pkg::OPB_W-1:0]   opb;
  logic [fesg_pkg::PROD_W-1:0]  prod;
  logic [fesg_pkg::PROD_W:0]    sum;
  logic signed [fesg_pkg::XS_W-1:0] xs;
  logic [fesg_pkg::X_W-1:0]     half;
  logic [fesg_pkg::COORD_W-1:0] row;
  logic                         last;

  logic                                out_valid_r;
  logic signed [fesg_pkg::COORD_W-1:0] left_r, right_r, row_r;
  logic [fesg_pkg::COLOR_W-1:0]        ocolor_r;
  logic                                last_r;

  assign a_in = (in_box_width[fesg_pkg::SIZE_W-1:1] > AXIS_MAX) ? AXIS_MAX
              : in_box_width[fesg_pkg::SIZE_W-1:1];
  assign b_in = (in_box_height[fesg_pkg::SIZE_W-1:1] > AXIS_MAX) ? AXIS_MAX
              : in_box_height[fesg_pkg::SIZE_W-1:1];

  always_comb begin
    unique case (ctrl.mul)
      fesg_pkg::MUL_AA: begin
        opa = fesg_pkg::OPA_W'(a_r);
        opb = fesg_pkg::OPB_W'(a_r);
      end
      fesg_pkg::MUL_BB: begin
        opa = fesg_pkg::OPA_W'(b_r);
        opb = fesg_pkg::OPB_W'(b_r);
      end
      fesg_pkg::MUL_A2B2: begin
        opa = a2_r;
        opb = fesg_pkg::OPB_W'(b2_r);
      end
      fesg_pkg::MUL_YY: begin
        opa = fesg_pkg::OPA_W'(y_r);
        opb = fesg_pkg::OPB_W'(y_r);
      end
      fesg_pkg::MUL_A2YY: begin
        opa = a2_r;
        opb = p_r[fesg_pkg::OPB_W-1:0];
      end
      fesg_pkg::MUL_XX: begin
        opa = fesg_pkg::OPA_W'(x_r);
        opb = fesg_pkg::OPB_W'(x_r);
      end
      fesg_pkg::MUL_B2XX: begin
        opa = b2_r;
        opb = p_r[fesg_pkg::OPB_W-1:0];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = fesg_pkg::PROD_W'(opa) * fesg_pkg::PROD_W'(opb);
  assign sum  = (fesg_pkg::PROD_W+1)'(p_r) + (fesg_pkg::PROD_W+1)'(ay_r);
  assign xs   = $signed({2'b00, x0_r}) - fesg_pkg::XS_W'(dx_r) + fesg_pkg::XS_W'(1);

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.b_zero   = (b_r == '0);
  assign stat.x_zero   = (x_r == '0);
  assign stat.outside  = (sum > (fesg_pkg::PROD_W+1)'(a2b2_r));
  assign stat.last_row = (y_r == b_r);

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      unique case (ctrl.mul)
        fesg_pkg::MUL_NONE: ;
        fesg_pkg::MUL_AA:   a2_r   <= prod[fesg_pkg::SQ_W-1:0];
        fesg_pkg::MUL_BB:   b2_r   <= prod[fesg_pkg::SQ_W-1:0];
        fesg_pkg::MUL_A2B2: a2b2_r <= prod[fesg_pkg::AB_W-1:0];
        fesg_pkg::MUL_A2YY: ay_r   <= prod[fesg_pkg::AB_W-1:0];
        default:            p_r    <= prod;
      endcase
      unique case (ctrl.act)
        fesg_pkg::ACT_LOAD: begin
          cx_r    <= in_center_x;
          cy_r    <= in_center_y;
          color_r <= in_fill_color;
          a_r     <= a_in;
          b_r     <= b_in;
          x0_r    <= fesg_pkg::X_W'(a_in);
          dx_r    <= '0;
          y_r     <= fesg_pkg::AXIS_W'(1);
        end
        fesg_pkg::ACT_XINIT: begin
          x_r <= xs[fesg_pkg::XS_W-1] ? '0 : xs[fesg_pkg::X_W-1:0];
        end
        fesg_pkg::ACT_CMP: begin
          if (stat.outside) begin
            x_r <= x_r - 1'b1;
          end
        end
        fesg_pkg::ACT_ADVANCE: begin
          dx_r <= $signed({1'b0, x0_r}) - $signed({1'b0, x_r});
          x0_r <= x_r;
          y_r  <= y_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    half = (ctrl.span == fesg_pkg::SPAN_CENTRE) ? fesg_pkg::X_W'(a_r) : x_r;
    unique case (ctrl.span)
      fesg_pkg::SPAN_BELOW: begin
        row  = fesg_pkg::COORD_W'(cy_r) + fesg_pkg::COORD_W'(y_r);
        last = 1'b0;
      end
      fesg_pkg::SPAN_ABOVE: begin
        row  = fesg_pkg::COORD_W'(cy_r) - fesg_pkg::COORD_W'(y_r);
        last = stat.last_row;
      end
      default: begin
        row  = fesg_pkg::COORD_W'(cy_r);
        last = stat.b_zero;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.go && ctrl.span != fesg_pkg::SPAN_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.span != fesg_pkg::SPAN_NONE) begin
      left_r   <= fesg_pkg::COORD_W'(cx_r) - fesg_pkg::COORD_W'(half);
      right_r  <= fesg_pkg::COORD_W'(cx_r) + fesg_pkg::COORD_W'(half);
      row_r    <= row;
      ocolor_r <= color_r;
      last_r   <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_left  = left_r;
  assign out_span_right = right_r;
  assign out_span_row   = row_r;
  assign out_span_color = ocolor_r;
  assign out_last_span  = last_r;

  a_dec_on_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.go && ctrl.act == fesg_pkg::ACT_CMP && stat.outside)
      |=> x_r == $past(x_r) - 1'b1)
    else $error("half-width not stepped down on outside test");

  a_span_width: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.go && ctrl.span == fesg_pkg::SPAN_BELOW) |-> x_r <= fesg_pkg::X_W'(a_r))
    else $error("row half-width beyond semi-axis");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.go && ctrl.span != fesg_pkg::SPAN_NONE) |-> (!out_valid_r || out_ready))
    else $error("span beat overwritten before taken");

endmodule

/* hw/rtl/filled_ellipse_span_generator_top.sv */
// Per request the sequencer squares a and b, forms a^2*b^2 and issues the centre span.
// Each further row pair sets the start half-width and y*y, forms a^2*y^2, then runs
// half-width tests (zero check, x*x, times b^2, compare) until the point is inside or x
// is zero, then issues the spans below and above and advances, except on the final row.
// Output back-pressure stalls each span. One shared multiplier driven by the microcode
// sequencer serves all products; a new request is taken only once its last span is issued.
// Reset: synchronous active-low rst_n returns the sequencer to fetch and drops out_valid.
module filled_ellipse_span_generator_top #(
  parameter int MAX_SEMI_AXIS = fesg_pkg::MAX_SEMI_AXIS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [fesg_pkg::POS_W-1:0]   in_center_x,
  input  logic        [fesg_pkg::POS_W-1:0]   in_center_y,
  input  logic        [fesg_pkg::SIZE_W-1:0]  in_box_width,
  input  logic        [fesg_pkg::SIZE_W-1:0]  in_box_height,
  input  logic        [fesg_pkg::COLOR_W-1:0] in_fill_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fesg_pkg::COORD_W-1:0] out_span_left,
  output logic signed [fesg_pkg::COORD_W-1:0] out_span_right,
  output logic signed [fesg_pkg::COORD_W-1:0] out_span_row,
  output logic        [fesg_pkg::COLOR_W-1:0] out_span_color,
  output logic                                out_last_span
);

  fesg_pkg::ctrl_t ctrl;
  fesg_pkg::stat_t stat;

  fesg_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  fesg_datapath #(
    .MAX_SEMI_AXIS (MAX_SEMI_AXIS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_box_width   (in_box_width),
    .in_box_height  (in_box_height),
    .in_fill_color  (in_fill_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_span_left  (out_span_left),
    .out_span_right (out_span_right),
    .out_span_row   (out_span_row),
    .out_span_color (out_span_color),
    .out_last_span  (out_last_span)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_AXIS = fesg_pkg::MAX_SEMI_AXIS_DEF;
  localparam int N_DIR    = 18;
  localparam int N_CHUNK  = 7;
  localparam int CHUNK_SZ = 50;

  typedef struct packed {
    logic [fesg_pkg::POS_W-1:0]   cx;
    logic [fesg_pkg::POS_W-1:0]   cy;
    logic [fesg_pkg::SIZE_W-1:0]  w;
    logic [fesg_pkg::SIZE_W-1:0]  h;
    logic [fesg_pkg::COLOR_W-1:0] color;
  } ellipse_req_t;

  typedef struct packed {
    logic signed [fesg_pkg::COORD_W-1:0] left;
    logic signed [fesg_pkg::COORD_W-1:0] right;
    logic signed [fesg_pkg::COORD_W-1:0] row;
    logic        [fesg_pkg::COLOR_W-1:0] color;
    logic                                last;
  } span_beat_t;

  typedef struct packed {
    ellipse_req_t req;
    logic         typed;
    span_beat_t   exp;
  } dir_row_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic        [fesg_pkg::POS_W-1:0]   in_center_x;
  logic        [fesg_pkg::POS_W-1:0]   in_center_y;
  logic        [fesg_pkg::SIZE_W-1:0]  in_box_width;
  logic        [fesg_pkg::SIZE_W-1:0]  in_box_height;
  logic        [fesg_pkg::COLOR_W-1:0] in_fill_color;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [fesg_pkg::COORD_W-1:0] out_span_left;
  logic signed [fesg_pkg::COORD_W-1:0] out_span_right;
  logic signed [fesg_pkg::COORD_W-1:0] out_span_row;
  logic        [fesg_pkg::COLOR_W-1:0] out_span_color;
  logic                                out_last_span;

  span_beat_t pending_spans[$];
  int         mismatches = 0;
  int         idle_pct = 25;

  // typed rows: single-span ellipses (box height below two, so b is zero), values read straight off the request
  dir_row_t dir_rows [N_DIR] = '{
    '{'{9'd0,   9'd0,   6'd0,  6'd0,  16'h0000}, 1'b1,
      '{11'sd0,   11'sd0,   11'sd0,   16'h0000, 1'b1}},
    '{'{9'd511, 9'd511, 6'd0,  6'd0,  16'hFFFF}, 1'b1,
      '{11'sd511, 11'sd511, 11'sd511, 16'hFFFF, 1'b1}},
    '{'{9'd0,   9'd0,   6'd63, 6'd0,  16'h1234}, 1'b1,
      '{-11'sd31, 11'sd31,  11'sd0,   16'h1234, 1'b1}},
    '{'{9'd511, 9'd511, 6'd63, 6'd1,  16'hABCD}, 1'b1,
      '{11'sd480, 11'sd542, 11'sd511, 16'hABCD, 1'b1}},
    '{'{9'd100, 9'd200, 6'd1,  6'd1,  16'hF800}, 1'b1,
      '{11'sd100, 11'sd100, 11'sd200, 16'hF800, 1'b1}},
    '{'{9'd0,   9'd0,   6'd62, 6'd0,  16'h07E0}, 1'b1,
      '{-11'sd31, 11'sd31,  11'sd0,   16'h07E0, 1'b1}},
    '{'{9'd0,   9'd0,   6'd0,  6'd63, 16'h001F}, 1'b0, '0},
    '{'{9'd511, 9'd511, 6'd63, 6'd63, 16'hFFFF}, 1'b0, '0},
    '{'{9'd0,   9'd0,   6'd63, 6'd63, 16'h0000}, 1'b0, '0},
    '{'{9'd256, 9'd256, 6'd2,  6'd2,  16'h5555}, 1'b0, '0},
    '{'{9'd300, 9'd100, 6'd62, 6'd2,  16'hAAAA}, 1'b0, '0},
    '{'{9'd50,  9'd60,  6'd2,  6'd62, 16'h3C3C}, 1'b0, '0},
    '{'{9'd511, 9'd0,   6'd63, 6'd62, 16'hC3C3}, 1'b0, '0},
    '{'{9'd0,   9'd511, 6'd62, 6'd63, 16'h0F0F}, 1'b0, '0},
    '{'{9'd255, 9'd255, 6'd40, 6'd20, 16'h8001}, 1'b0, '0},
    '{'{9'd128, 9'd384, 6'd7,  6'd13, 16'h7FFE}, 1'b0, '0},
    '{'{9'd384, 9'd128, 6'd3,  6'd3,  16'h0001}, 1'b0, '0},
    '{'{9'd17,  9'd490, 6'd31, 6'd31, 16'h8000}, 1'b0, '0}
  };

  filled_ellipse_span_generator_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_fill_color (in_fill_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_span_left (out_span_left),
    .out_span_right(out_span_right),
    .out_span_row  (out_span_row),
    .out_span_color(out_span_color),
    .out_last_span (out_last_span)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic span_beat_t make_span(int l, int rt, int row,
                                           logic [fesg_pkg::COLOR_W-1:0] color, bit last);
    span_beat_t s;
    s.left  = l[fesg_pkg::COORD_W-1:0];
    s.right = rt[fesg_pkg::COORD_W-1:0];
    s.row   = row[fesg_pkg::COORD_W-1:0];
    s.color = color;
    s.last  = last;
    return s;
  endfunction

  // centre row, then mirrored row pairs with the half-width stepped down
  task automatic predict_spans(input ellipse_req_t r);
    int cx, cy, a, b, a2, b2, a2b2, x0, dx, x;
    cx = int'(r.cx);
    cy = int'(r.cy);
    a  = int'(r.w) >> 1;
    b  = int'(r.h) >> 1;
    if (a > MAX_AXIS) a = MAX_AXIS;
    if (b > MAX_AXIS) b = MAX_AXIS;
    a2   = a * a;
    b2   = b * b;
    a2b2 = a2 * b2;
    pending_spans.push_back(make_span(cx - a, cx + a, cy, r.color, b == 0));
    x0 = a;
    dx = 0;
    for (int y = 1; y <= b; y++) begin
      x = x0 - dx + 1;
      if (x < 0) x = 0;
      while (x > 0 && b2 * x * x + a2 * y * y > a2b2) x--;
      dx = x0 - x;
      x0 = x;
      pending_spans.push_back(make_span(cx - x0, cx + x0, cy + y, r.color, 1'b0));
      pending_spans.push_back(make_span(cx - x0, cx + x0, cy - y, r.color, y == b));
    end
  endtask

  task automatic send_request(input ellipse_req_t r, input bit typed, input span_beat_t exp);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    in_center_x   = r.cx;
    in_center_y   = r.cy;
    in_box_width  = r.w;
    in_box_height = r.h;
    in_fill_color = r.color;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (typed) pending_spans.push_back(exp);
    else predict_spans(r);
  endtask

  initial begin : stimulus
    ellipse_req_t r;
    int sel;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_center_x   = '0;
    in_center_y   = '0;
    in_box_width  = '0;
    in_box_height = '0;
    in_fill_color = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIR; i++)
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);

    // hold off until the block has drained
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_spans.size() != 0) @(negedge clk);

    for (int c = 0; c < N_CHUNK; c++) begin
      idle_pct = (c == N_CHUNK - 1) ? 0 : ((c % 2 == 0) ? 20 : 0);
      if (c == 3) begin
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_spans.size() != 0) @(negedge clk);
      end
      for (int k = 0; k < CHUNK_SZ; k++) begin
        r.cx    = fesg_pkg::POS_W'($urandom_range(0, 511));
        r.cy    = fesg_pkg::POS_W'($urandom_range(0, 511));
        r.color = fesg_pkg::COLOR_W'($urandom_range(0, 65535));
        sel     = int'($urandom_range(0, 19));
        if (sel == 0) begin
          r.w = fesg_pkg::SIZE_W'($urandom_range(62, 63));
          r.h = fesg_pkg::SIZE_W'($urandom_range(62, 63));
        end else if (sel < 5) begin
          r.w = fesg_pkg::SIZE_W'($urandom_range(0, 63));
          r.h = fesg_pkg::SIZE_W'($urandom_range(0, 63));
        end else begin
          r.w = fesg_pkg::SIZE_W'($urandom_range(0, 15));
          r.h = fesg_pkg::SIZE_W'($urandom_range(0, 15));
        end
        send_request(r, 1'b0, '0);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_spans.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (mismatches == 0 && pending_spans.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    span_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected span beat: left %0d right %0d row %0d",
               out_span_left, out_span_right, out_span_row);
        mismatches++;
      end else begin
        e = pending_spans.pop_front();
        if (out_span_left !== e.left) begin
          $error("span_left: expected %0d, got %0d", e.left, out_span_left);
          mismatches++;
        end
        if (out_span_right !== e.right) begin
          $error("span_right: expected %0d, got %0d", e.right, out_span_right);
          mismatches++;
        end
        if (out_span_row !== e.row) begin
          $error("span_row: expected %0d, got %0d", e.row, out_span_row);
          mismatches++;
        end
        if (out_span_color !== e.color) begin
          $error("span_color: expected %h, got %h", e.color, out_span_color);
          mismatches++;
        end
        if (out_last_span !== e.last) begin
          $error("last_span: expected %0d, got %0d", e.last, out_last_span);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
